/* hdl/compass_frame_decoder_averager_assert.svh */
// Assertion macros for the compass frame decoder/averager.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef COMPASS_FRAME_DECODER_AVERAGER_ASSERT_SVH
`define COMPASS_FRAME_DECODER_AVERAGER_ASSERT_SVH

// consequent checked in the same cycle
`define CFDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfda check failed");

// consequent checked in the next cycle
`define CFDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfda check failed");

`endif

/* hdl/cfda_pkg.sv */
// Shared types and constants for the compass frame decoder/averager.
// No dependencies.
`timescale 1ns / 1ps

package cfda_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ANGLE_W   = 19;
  localparam int unsigned TOTAL_W   = 23;
  localparam int unsigned MAG_W     = 22;
  localparam int unsigned RECIP_W   = 23;
  localparam int unsigned PROD_W    = MAG_W + RECIP_W;
  localparam int unsigned DIV_SHIFT = 26;
  localparam int unsigned POS_W     = 3;

  localparam logic [BYTE_W-1:0]  HDR0       = 8'h0D;
  localparam logic [BYTE_W-1:0]  HDR1       = 8'h0A;
  localparam logic [BYTE_W-1:0]  ASCII_ZERO = 8'h30;
  localparam logic [POS_W-1:0]   POS_LAST   = 3'd7;
  // ceil(2^26 / 13); exact floor(m / 13) for every m below 2^22
  localparam logic [RECIP_W-1:0] RECIP13    = 23'd5162221;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [TOTAL_W-1:0] total_t;

  // frame result waiting for the divider
  typedef struct packed {
    logic   valid;
    angle_t angle;
    total_t total;
  } frame_res_t;

  function automatic logic signed [BYTE_W:0] ascii_digit(input logic [BYTE_W-1:0] b);
    return $signed({1'b0, b}) - $signed({1'b0, ASCII_ZERO});
  endfunction

  function automatic angle_t decode_angle(input logic [BYTE_W-1:0] b2,
                                          input logic [BYTE_W-1:0] b3,
                                          input logic [BYTE_W-1:0] b4,
                                          input logic [BYTE_W-1:0] b6);
    angle_t a2, a3, a4, a6;
    a2 = ANGLE_W'(ascii_digit(b2));
    a3 = ANGLE_W'(ascii_digit(b3));
    a4 = ANGLE_W'(ascii_digit(b4));
    a6 = ANGLE_W'(ascii_digit(b6));
    return a2 * 19'sd1000 + a3 * 19'sd100 + a4 * 19'sd10 + a6;
  endfunction

endpackage

/* hdl/cfda_div13.sv */
// Signed divide by 13, truncating toward zero, by reciprocal multiply.
// One register stage (product and sign); depends on cfda_pkg.
`timescale 1ns / 1ps

module cfda_div13 import cfda_pkg::*; (
  input  logic   clk_i,
  input  logic   load_i,
  input  total_t total_i,
  output angle_t quot_o
);

  logic [TOTAL_W-1:0] mag_full;
  logic [MAG_W-1:0]   mag;
  logic [PROD_W-1:0]  prod_d, prod_q;
  logic               neg_q;
  angle_t             q_abs;

  assign mag_full = total_i[TOTAL_W-1] ? TOTAL_W'(-total_i) : TOTAL_W'(total_i);
  assign mag      = mag_full[MAG_W-1:0];
  assign prod_d   = PROD_W'(mag) * PROD_W'(RECIP13);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      neg_q  <= total_i[TOTAL_W-1];
    end
  end

  assign q_abs  = $signed(prod_q[DIV_SHIFT +: ANGLE_W]);
  assign quot_o = neg_q ? -q_abs : q_abs;

endmodule

/* hdl/compass_frame_decoder_averager.sv */
// Compass frame decoder and weighted heading averager (top level).
// A result passes s1, s2 and the output register to m_*. Throughput: one byte per cycle,
// save a frame's last byte while s1 can't drain; the frame pipeline (check, multiply, output)
// stalls on m_tready_i. Reset: async active low clears byte count, held angle, history,
// valid flags. Uses cfda_pkg, cfda_div13 and compass_frame_decoder_averager_assert.svh.
`timescale 1ns / 1ps

module compass_frame_decoder_averager import cfda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] rx_byte
  // frame results out
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // [18:0] angle_tenths, [37:19] average_tenths,
                                   // [39:38] zero
  output logic        m_tuser_o    // [0] frame_valid
);

  `include "compass_frame_decoder_averager_assert.svh"

  // ---------------------------------------------------------------------------
  // Byte collection. Slots 0..6 are stored; slot 7 (checksum) is used straight
  // from the bus when the frame completes. Framing follows the byte count since
  // reset, with no resync.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BYTE_W-1:0] frame_q [0:6];

  logic s_accept, frame_done;
  logic s1_ready, s2_ready, out_ready;

  // Only the frame-completing byte needs room in the pipeline.
  assign s_tready_o = (pos_q != POS_LAST) || s1_ready;
  assign s_accept   = s_tvalid_i && s_tready_o;
  assign frame_done = s_accept && (pos_q == POS_LAST);
  assign pos_d      = pos_q + POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (s_accept) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept && (pos_q != POS_LAST)) begin
      frame_q[pos_q] <= s_tdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame check and angle decode
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] csum;
  logic              hdr_ok, frame_ok;
  angle_t            held_q, held_d;
  angle_t            hist_q [0:3];   // [3] newest, [0] oldest
  total_t            total;

  assign csum = frame_q[0] + frame_q[1] + frame_q[2] + frame_q[3]
              + frame_q[4] + frame_q[5] + frame_q[6];
  assign hdr_ok   = (frame_q[0] == HDR0) && (frame_q[1] == HDR1);
  assign frame_ok = hdr_ok && (csum == s_tdata_i);
  assign held_d   = frame_ok ? decode_angle(frame_q[2], frame_q[3], frame_q[4], frame_q[6])
                             : held_q;

  // Sum over the history as it stands after this frame's shift:
  // newest = held_d, then hist[3], hist[2], and hist[1] becomes the oldest (x10).
  assign total = TOTAL_W'(held_d) + TOTAL_W'(hist_q[3]) + TOTAL_W'(hist_q[2])
               + (TOTAL_W'(hist_q[1]) <<< 3) + (TOTAL_W'(hist_q[1]) <<< 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      hist_q[0] <= '0;
      hist_q[1] <= '0;
      hist_q[2] <= '0;
      hist_q[3] <= '0;
    end else if (frame_done) begin
      held_q    <= held_d;
      hist_q[0] <= hist_q[1];
      hist_q[1] <= hist_q[2];
      hist_q[2] <= hist_q[3];
      hist_q[3] <= held_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline: s1 (checked frame + sum) -> s2 (reciprocal product) -> output reg
  // ---------------------------------------------------------------------------
  frame_res_t s1_q;
  logic       s1_v_q, s2_v_q, s2_valid_q;
  angle_t     s2_angle_q;
  logic       s2_load, out_load;
  angle_t     avg;

  assign out_ready = !m_tvalid_o || m_tready_i;
  assign s2_ready  = !s2_v_q || out_ready;
  assign s1_ready  = !s1_v_q || s2_ready;
  assign s2_load   = s1_v_q && s2_ready;
  assign out_load  = s2_v_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      m_tvalid_o <= 1'b0;
    end else begin
      if (frame_done) begin
        s1_v_q <= 1'b1;
      end else if (s2_load) begin
        s1_v_q <= 1'b0;
      end
      if (s2_load) begin
        s2_v_q <= 1'b1;
      end else if (out_load) begin
        s2_v_q <= 1'b0;
      end
      if (out_load) begin
        m_tvalid_o <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      s1_q.valid <= frame_ok;
      s1_q.angle <= held_d;
      s1_q.total <= total;
    end
    if (s2_load) begin
      s2_valid_q <= s1_q.valid;
      s2_angle_q <= s1_q.angle;
    end
    if (out_load) begin
      m_tdata_o <= {2'b00, avg, s2_angle_q};
      m_tuser_o <= s2_valid_q;
    end
  end

  cfda_div13 u_div13 (
    .clk_i   (clk_i),
    .load_i  (s2_load),
    .total_i (s1_q.total),
    .quot_o  (avg)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `CFDA_ASSERT_NEXT(a_pos_step, s_accept, pos_q == ($past(pos_q) + POS_W'(1)))
  `CFDA_ASSERT_NOW(a_stall_only_last, !s_tready_o, (pos_q == POS_LAST) && s1_v_q)
  `CFDA_ASSERT_NEXT(a_frame_enters, frame_done, s1_v_q)
  `CFDA_ASSERT_NEXT(a_s1_holds, s1_v_q && !s2_ready, s1_v_q && $stable(s1_q))

endmodule
